// File: src/nts_pkg.sv
// nts_pkg: shared types and constants of the nibble trie key store
// used by nts_ctrl, nts_dp and nibble_trie_key_store_core; no dependencies
package nts_pkg;

    localparam int NIBBLE_BITS = 4;
    localparam int FANOUT      = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  key_byte;
        logic        last_byte;
        logic [31:0] store_value;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] found_value;
        logic        key_present;
        logic [7:0]  key_count;
        logic [8:0]  nodes_in_use;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CSWEEP,
        S_CEMIT,
        S_RD,
        S_LK,
        S_ALLOC,
        S_ZERO,
        S_NXT,
        S_FRD,
        S_FIN
    } ctl_state_t;

    typedef struct packed {
        logic take;
        logic sweep;
        logic emit_clr;
        logic rd_link;
        logic eval;
        logic alloc;
        logic zero;
        logic next_phase;
        logic frd;
        logic fin;
    } ctl_cmd_t;

    typedef struct packed {
        logic req_clear;
        logic walk_ok;
        logic need_alloc;
        logic sweep_last;
        logic phase_hi;
        logic last_byte;
        logic out_busy;
    } dp_sts_t;

endpackage

// File: src/nts_ram.sv
// nts_ram: generic single write port RAM with a registered read port
// no dependencies
module nts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/nts_ctrl.sv
// nts_ctrl: sequencer of the nibble trie key store
// depends on nts_pkg
module nts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  nts_pkg::dp_sts_t  sts,
    output nts_pkg::ctl_cmd_t cmd
);
    import nts_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.req_clear ? S_CSWEEP : S_RD;
                end
            end
            S_CSWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_CEMIT;
                end
            end
            S_CEMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:    state_next = sts.walk_ok ? S_LK : S_NXT;
            S_LK:    state_next = sts.need_alloc ? S_ALLOC : S_NXT;
            S_ALLOC: state_next = S_ZERO;
            S_ZERO:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_NXT;
                end
            end
            S_NXT:
            begin
                priority if (!sts.phase_hi)
                begin
                    state_next = S_RD;
                end
                else if (sts.last_byte)
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FRD:   state_next = S_FIN;
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_INIT:   cmd.sweep      = 1'b1;
            S_IDLE:   cmd.take       = req_valid;
            S_CSWEEP: cmd.sweep      = 1'b1;
            S_CEMIT:  cmd.emit_clr   = !sts.out_busy;
            S_RD:     cmd.rd_link    = sts.walk_ok;
            S_LK:     cmd.eval       = 1'b1;
            S_ALLOC:  cmd.alloc      = 1'b1;
            S_ZERO:   cmd.zero       = 1'b1;
            S_NXT:    cmd.next_phase = !sts.phase_hi;
            S_FRD:    cmd.frd        = 1'b1;
            S_FIN:
            begin
                cmd.frd = 1'b1;
                cmd.fin = !sts.out_busy;
            end
            default:  cmd = '0;
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    // item taken only in idle, clear sweep handed to emit, allocation followed by link clearing
    a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (state_reg == S_IDLE))
        else $error("item taken outside idle");
    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CSWEEP && sts.sweep_last) |=> (state_reg == S_CEMIT))
        else $error("clear sweep did not hand over to emit");
    a_alloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |=> (state_reg == S_ZERO))
        else $error("allocation not followed by link clearing");

endmodule

// File: src/nts_dp.sv
// nts_dp: walk registers, node pool counters, trie memories and result register
// depends on nts_pkg and nts_ram
module nts_dp #(
    parameter int POOL_NODES  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nts_pkg::req_t     req,
    input  nts_pkg::ctl_cmd_t cmd,
    output nts_pkg::dp_sts_t  sts,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output nts_pkg::rsp_t     rsp
);
    import nts_pkg::*;

    localparam int NW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int PW  = NW + 1;
    localparam int LAW = NW + NIBBLE_BITS;
    localparam int DW  = VALUE_WIDTH + 1;

    // latched item and walk state
    req_t                   item_reg;
    mode_t                  key_mode_reg;
    logic                   mid_key_reg;
    logic [NW-1:0]          walk_node_reg;
    status_t                walk_status_reg;
    logic                   phase_reg;
    logic [PW-1:0]          pool_fill_reg;
    logic [PW-1:0]          keys_reg;
    logic [NIBBLE_BITS-1:0] cnt_reg;
    logic                   out_valid_reg;
    rsp_t                   out_reg;

    // memory ports
    logic                   link_we;
    logic [LAW-1:0]         link_waddr;
    logic [NW-1:0]          link_wdata;
    logic [LAW-1:0]         link_raddr;
    logic [NW-1:0]          link_rdata;
    logic                   node_we;
    logic [NW-1:0]          node_waddr;
    logic [DW-1:0]          node_wdata;
    logic [DW-1:0]          node_rdata;

    logic [NIBBLE_BITS-1:0] nib;
    logic                   pool_full;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [31:0]            rd_value32;
    logic [7:0]             keys8;
    logic [8:0]             pool9;
    logic                   rd_mark;
    logic [VALUE_WIDTH-1:0] rd_value;

    // finish step results
    status_t                fin_status;
    logic                   fin_write;
    logic [DW-1:0]          fin_wdata;
    logic [PW-1:0]          fin_keys;
    logic                   fin_present;

    assign nib       = phase_reg ? item_reg.key_byte[NIBBLE_BITS-1:0]
                                 : item_reg.key_byte[7:NIBBLE_BITS];
    assign pool_full = (pool_fill_reg >= PW'(POOL_NODES));
    assign rd_mark   = node_rdata[DW-1];
    assign rd_value  = node_rdata[VALUE_WIDTH-1:0];

    // width fitting of values and counts
    always_comb
    begin
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            in_value[i] = (i < 32) ? item_reg.store_value[i % 32] : 1'b0;
        end
        for (int i = 0; i < 32; i++)
        begin
            rd_value32[i] = (i < VALUE_WIDTH) ? rd_value[i % VALUE_WIDTH] : 1'b0;
        end
        for (int i = 0; i < 8; i++)
        begin
            keys8[i] = (i < PW) ? fin_keys[i % PW] : 1'b0;
        end
        for (int i = 0; i < 9; i++)
        begin
            pool9[i] = (i < PW) ? pool_fill_reg[i % PW] : 1'b0;
        end
    end

    // terminal check and key count update at the end of a key
    always_comb
    begin
        fin_status  = walk_status_reg;
        fin_write   = 1'b0;
        fin_wdata   = {1'b1, in_value};
        fin_keys    = keys_reg;
        fin_present = 1'b0;
        if (walk_status_reg == ST_OK)
        begin
            priority if (key_mode_reg == MODE_INSERT)
            begin
                fin_write = 1'b1;
                if (!rd_mark)
                begin
                    fin_keys = keys_reg + PW'(1);
                end
            end
            else if (!rd_mark)
            begin
                fin_status = ST_NOTFOUND;
            end
            else if (key_mode_reg == MODE_SEARCH)
            begin
                fin_present = 1'b1;
            end
            else
            begin
                fin_write = 1'b1;
                fin_wdata = {1'b0, rd_value};
                if (keys_reg != '0)
                begin
                    fin_keys = keys_reg - PW'(1);
                end
            end
        end
    end

    // memory port selection
    always_comb
    begin
        link_we    = cmd.sweep | cmd.zero | cmd.alloc;
        link_waddr = {walk_node_reg, cnt_reg};
        link_wdata = '0;
        if (cmd.sweep)
        begin
            link_waddr = {{NW{1'b0}}, cnt_reg};
        end
        else if (cmd.alloc)
        begin
            link_waddr = {walk_node_reg, nib};
            link_wdata = pool_fill_reg[NW-1:0];
        end
        link_raddr = {walk_node_reg, nib};

        node_we    = (cmd.sweep && cnt_reg == '0) | cmd.alloc | (cmd.fin && fin_write);
        node_waddr = walk_node_reg;
        node_wdata = '0;
        if (cmd.sweep)
        begin
            node_waddr = '0;
        end
        else if (cmd.alloc)
        begin
            node_waddr = pool_fill_reg[NW-1:0];
        end
        else
        begin
            node_wdata = fin_wdata;
        end
    end

    // item latch, walk and pool registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg    <= MODE_INSERT;
            mid_key_reg     <= 1'b0;
            walk_node_reg   <= '0;
            walk_status_reg <= ST_OK;
            phase_reg       <= 1'b0;
            pool_fill_reg   <= PW'(1);
            keys_reg        <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                phase_reg <= 1'b0;
                if (req.mode == MODE_CLEAR)
                begin
                    mid_key_reg     <= 1'b0;
                    walk_node_reg   <= '0;
                    walk_status_reg <= ST_OK;
                    key_mode_reg    <= MODE_INSERT;
                    pool_fill_reg   <= PW'(1);
                    keys_reg        <= '0;
                    cnt_reg         <= '0;
                end
                else if (!mid_key_reg)
                begin
                    mid_key_reg     <= 1'b1;
                    walk_node_reg   <= '0;
                    walk_status_reg <= ST_OK;
                    key_mode_reg    <= req.mode;
                end
            end
            if (cmd.sweep || cmd.zero)
            begin
                cnt_reg <= cnt_reg + NIBBLE_BITS'(1);
            end
            if (cmd.eval)
            begin
                priority if (link_rdata != '0)
                begin
                    walk_node_reg <= link_rdata;
                end
                else if (key_mode_reg != MODE_INSERT)
                begin
                    walk_status_reg <= ST_NOTFOUND;
                end
                else if (pool_full)
                begin
                    walk_status_reg <= ST_FULL;
                end
            end
            if (cmd.alloc)
            begin
                walk_node_reg <= pool_fill_reg[NW-1:0];
                pool_fill_reg <= pool_fill_reg + PW'(1);
                cnt_reg       <= '0;
            end
            if (cmd.next_phase)
            begin
                phase_reg <= 1'b1;
            end
            if (cmd.fin)
            begin
                mid_key_reg     <= 1'b0;
                keys_reg        <= fin_keys;
                walk_node_reg   <= '0;
                walk_status_reg <= ST_OK;
            end
        end
    end

    // payload latch of the incoming item
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= req;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin || cmd.emit_clr)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            out_reg.status       <= fin_status;
            out_reg.found_value  <= fin_present ? rd_value32 : 32'd0;
            out_reg.key_present  <= fin_present;
            out_reg.key_count    <= keys8;
            out_reg.nodes_in_use <= pool9;
        end
        else if (cmd.emit_clr)
        begin
            // the store is empty after a clear
            out_reg.status       <= ST_OK;
            out_reg.found_value  <= 32'd0;
            out_reg.key_present  <= 1'b0;
            out_reg.key_count    <= 8'd0;
            out_reg.nodes_in_use <= pool9;
        end
    end

    // memories
    nts_ram #(
        .WIDTH (NW),
        .DEPTH (POOL_NODES * FANOUT)
    ) u_links (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    nts_ram #(
        .WIDTH (DW),
        .DEPTH (POOL_NODES)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (node_we),
        .wr_addr (node_waddr),
        .wr_data (node_wdata),
        .rd_addr (walk_node_reg),
        .rd_data (node_rdata)
    );

    // status to the controller
    assign sts.req_clear  = (req.mode == MODE_CLEAR);
    assign sts.walk_ok    = (walk_status_reg == ST_OK);
    assign sts.need_alloc = (link_rdata == '0) && (key_mode_reg == MODE_INSERT) && !pool_full;
    assign sts.sweep_last = (cnt_reg == {NIBBLE_BITS{1'b1}});
    assign sts.phase_hi   = phase_reg;
    assign sts.last_byte  = item_reg.last_byte;
    assign sts.out_busy   = out_valid_reg & rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // pool, walk and key count bounds, and pool growth on allocation
    a_pool_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pool_fill_reg >= PW'(1)) && (pool_fill_reg <= PW'(POOL_NODES)))
        else $error("node pool count out of range");
    a_walk_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, walk_node_reg} < pool_fill_reg)
        else $error("walk reached an unallocated node");
    a_keys_bound: assert property (@(posedge clk) disable iff (!rst_n)
        keys_reg < pool_fill_reg)
        else $error("more stored keys than nodes");
    a_alloc_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |=> (pool_fill_reg == $past(pool_fill_reg) + PW'(1)))
        else $error("allocation did not advance the pool");

endmodule

// File: src/nibble_trie_key_store_core.sv
// Nibble trie key store: a key-value store on a radix-16 trie over a node pool.
//
// Request channel (req_valid, req_stall, req): one item per key byte, last_byte
// ends the key. The mode of a key's first byte holds for the whole key; clear
// acts at once, even inside a key, and answers ok.
// Response channel (rsp_valid, rsp_stall, rsp): one item per finished key or
// clear, none for the other bytes.
// Walk: each byte walks two nibbles through the link memory. A nibble reads
// and tests its link (RD, LK); when insert allocates a node it writes the link
// (ALLOC) and clears the new node's links one at a time (ZERO), then it steps
// on (NXT); once the walk has failed a nibble takes only the read and the step.
// The input stays stalled until the byte is done; the last byte of a key adds a
// node memory read and the finish step, and clear sweeps the root's links and mark.
// Reset: a clearing pass empties the root's links and mark;
// no item is taken until it ends.
// A stalled response is held in the output register; the next request is
// still taken and worked on, and only its own result waits for the register.
// Depends on nts_pkg, nts_ctrl, nts_dp and nts_ram.
module nibble_trie_key_store_core #(
    parameter int POOL_NODES  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  nts_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output nts_pkg::rsp_t rsp
);
    import nts_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // sequencer
    nts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // trie datapath
    nts_dp #(
        .POOL_NODES  (POOL_NODES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// File: bench/tb_nibble_trie_key_store_core.sv
// Testbench for nibble_trie_key_store_core: drives key bytes, predicts each result
// with a behavioural trie and compares field by field. Depends on nts_pkg and the RTL.
`timescale 1ns / 100ps

module tb_nibble_trie_key_store_core;
    import nts_pkg::*;

    localparam int POOL = 256;
    localparam int CYCLE_LIMIT = 1500000;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    // predictor state
    logic [7:0]  trie_link [POOL*16];
    logic        trie_term [POOL];
    logic [31:0] trie_val [POOL];
    int          fill_cnt;
    int          key_total;
    int          walk_at;
    status_t     walk_st;
    mode_t       cur_mode;
    logic        in_key;

    rsp_t  pending_rsp [$];
    int    mismatch_cnt;
    int    cycle_cnt;
    int    hold_off;
    logic  bench_done;

    nibble_trie_key_store_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // empty the whole predicted trie
    task automatic wipe_trie();
        for (int i = 0; i < POOL*16; i++)
        begin
            trie_link[i] = '0;
        end
        for (int i = 0; i < POOL; i++)
        begin
            trie_term[i] = 1'b0;
            trie_val[i]  = '0;
        end
        fill_cnt  = 1;
        key_total = 0;
        walk_at   = 0;
        walk_st   = ST_OK;
        cur_mode  = MODE_INSERT;
        in_key    = 1'b0;
    endtask

    // one nibble step down the trie, allocating on insert
    task automatic walk_nibble(input logic [3:0] nib);
        int slot;
        if (walk_st != ST_OK)
        begin
            return;
        end
        slot = walk_at * 16 + nib;
        if (trie_link[slot] == 0)
        begin
            if (cur_mode != MODE_INSERT)
            begin
                walk_st = ST_NOTFOUND;
                return;
            end
            if (fill_cnt >= POOL)
            begin
                walk_st = ST_FULL;
                return;
            end
            for (int i = 0; i < 16; i++)
            begin
                trie_link[fill_cnt*16 + i] = '0;
            end
            trie_term[fill_cnt] = 1'b0;
            trie_val[fill_cnt]  = '0;
            trie_link[slot]     = fill_cnt[7:0];
            fill_cnt++;
        end
        walk_at = trie_link[slot];
    endtask

    // work out the result, if any, of one accepted item
    task automatic predict_trie(input req_t it);
        rsp_t r;
        r = '0;
        if (it.mode == MODE_CLEAR)
        begin
            wipe_trie();
            r.status       = ST_OK;
            r.nodes_in_use = 9'(fill_cnt);
            pending_rsp.push_back(r);
            return;
        end
        if (!in_key)
        begin
            walk_at  = 0;
            walk_st  = ST_OK;
            cur_mode = it.mode;
            in_key   = 1'b1;
        end
        walk_nibble(it.key_byte[7:4]);
        walk_nibble(it.key_byte[3:0]);
        if (!it.last_byte)
        begin
            return;
        end
        in_key   = 1'b0;
        r.status = walk_st;
        if (walk_st == ST_OK)
        begin
            if (cur_mode == MODE_INSERT)
            begin
                if (!trie_term[walk_at])
                begin
                    key_total++;
                end
                trie_term[walk_at] = 1'b1;
                trie_val[walk_at]  = it.store_value;
            end
            else if (!trie_term[walk_at])
            begin
                r.status = ST_NOTFOUND;
            end
            else if (cur_mode == MODE_SEARCH)
            begin
                r.found_value = trie_val[walk_at];
                r.key_present = 1'b1;
            end
            else
            begin
                trie_term[walk_at] = 1'b0;
                if (key_total > 0)
                begin
                    key_total--;
                end
            end
        end
        r.key_count    = 8'(key_total);
        r.nodes_in_use = 9'(fill_cnt);
        walk_at = 0;
        walk_st = ST_OK;
        pending_rsp.push_back(r);
    endtask

    // send one item, with a random gap ahead of it now and then
    task automatic send_item(input mode_t m, input logic [7:0] b, input logic l,
                             input logic [31:0] v);
        req_t it;
        it.mode        = m;
        it.key_byte    = b;
        it.last_byte   = l;
        it.store_value = v;
        if ($urandom_range(0, 9) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        predict_trie(it);
    endtask

    task automatic send_key(input mode_t m, input logic [7:0] k [$], input logic [31:0] v);
        for (int i = 0; i < k.size(); i++)
        begin
            send_item(m, k[i], i == k.size() - 1, v);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    // extremes of bytes and values, every mode, stray mode inside a key
    task automatic test_directed();
        logic [7:0] k [$];
        k = '{8'h00, 8'hFF};
        send_key(MODE_SEARCH, k, 32'h0);
        send_key(MODE_INSERT, k, 32'hFFFF_FFFF);
        send_key(MODE_SEARCH, k, 32'h0);
        send_key(MODE_INSERT, k, 32'h0);
        send_key(MODE_SEARCH, k, 32'h0);
        k = '{8'h00};
        send_key(MODE_SEARCH, k, 32'h0);
        k = '{8'hA5, 8'h5A};
        send_item(MODE_INSERT, 8'hA5, 1'b0, 32'h0);
        send_item(MODE_SEARCH, 8'h5A, 1'b1, 32'h8000_0001);
        send_key(MODE_REMOVE, k, 32'h0);
        send_key(MODE_REMOVE, k, 32'h0);
        send_key(MODE_SEARCH, k, 32'h0);
        send_item(MODE_INSERT, 8'h12, 1'b0, 32'h0);
        send_item(MODE_CLEAR, 8'h34, 1'b1, 32'h0);
        send_key(MODE_SEARCH, '{8'h00, 8'hFF}, 32'h0);
        send_item(MODE_SEARCH, 8'h77, 1'b0, 32'h0);
        send_item(MODE_INSERT, 8'h77, 1'b1, 32'h0);
        send_item(MODE_CLEAR, 8'h00, 1'b0, 32'h0);
    endtask

    // insert 80 random three-byte keys to run the pool full, then search a fixed key and clear
    task automatic test_pool_full();
        logic [7:0] k [$];
        for (int n = 0; n < 80; n++)
        begin
            k = '{8'($urandom), 8'($urandom), 8'($urandom)};
            send_key(MODE_INSERT, k, $urandom);
        end
        k = '{8'hC3, 8'h3C, 8'h99};
        send_key(MODE_SEARCH, k, 32'h0);
        send_item(MODE_CLEAR, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    endtask

    // random keys from a small pool of prefixes; mostly well formed
    task automatic test_random(input int n_items);
        logic [7:0] k [$];
        logic [7:0] known [$][$];
        int sent;
        int len;
        int pick;
        mode_t m;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                send_item(MODE_CLEAR, 8'($urandom), 1'($urandom), $urandom);
                known = {};
                sent++;
                continue;
            end
            if (known.size() != 0 && pick < 60)
            begin
                k = known[$urandom_range(0, known.size() - 1)];
                if ($urandom_range(0, 3) == 0)
                begin
                    k[k.size() - 1] = 8'($urandom);
                end
            end
            else
            begin
                len = $urandom_range(1, 4);
                k = {};
                for (int i = 0; i < len; i++)
                begin
                    k.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) :
                                8'($urandom_range(0, 3) * 8'h41));
                end
            end
            m = mode_t'($urandom_range(0, 2));
            if (m == MODE_INSERT && known.size() < 64)
            begin
                known.push_back(k);
            end
            for (int i = 0; i < k.size(); i++)
            begin
                send_item(i == 0 ? m : mode_t'($urandom_range(0, 2)), k[i],
                          i == k.size() - 1, $urandom);
            end
            sent += k.size();
            if (fill_cnt > 200 && $urandom_range(0, 7) == 0)
            begin
                send_item(MODE_CLEAR, 8'h00, 1'b0, 32'h0);
                known = {};
                sent++;
            end
        end
    endtask

    // receiver stalls on its own pattern, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_off  <= 0;
        end
        else if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            rsp_stall <= (hold_off > 1);
        end
        else if (cycle_cnt == 3000)
        begin
            hold_off  <= 1500;
            rsp_stall <= 1'b1;
        end
        else if (cycle_cnt[10:9] == 2'b11)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // compare each result with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("unexpected result %p", rsp);
                end
            end
            else
            begin
                rsp_t want;
                want = pending_rsp.pop_front();
                if (rsp.status != want.status || rsp.found_value != want.found_value ||
                    rsp.key_present != want.key_present ||
                    rsp.key_count != want.key_count ||
                    rsp.nodes_in_use != want.nodes_in_use)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("mismatch: expected %p got %p", want, rsp);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT && !bench_done)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        bench_done   = 1'b0;
        wipe_trie();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pool_full();
        test_random(980);
        wait_drained();
        bench_done = 1'b1;
        if (mismatch_cnt == 0 && pending_rsp.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
